// ----- design/qic_pkg.sv -----
`default_nettype none

package qic_pkg;

    localparam int DEF_CURRENCIES = 8;
    localparam int CUR_W          = 4;
    localparam int VAR_W          = 6;
    localparam int RATE_W         = 16;
    localparam int WEIGHT_W       = 16;
    localparam int OUT_W          = 32;
    localparam int ACC_W          = 36;
    localparam int TERM_W         = 21;
    localparam int DIAG_W         = 26;
    localparam int PROD_W         = 33;
    localparam int CMP_W          = 10;
    localparam int CFG_IDX_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LINK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIAG  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FORM  = CFG_IDX_W'(3);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(256);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic signed [TERM_W-1:0] HALF_Q     = TERM_W'(128);
    localparam logic signed [TERM_W-1:0] ONE_Q      = TERM_W'(256);
    localparam logic signed [TERM_W-1:0] ONE_HALF_Q = TERM_W'(384);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MULT,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic accept_read;
        logic div_step;
        logic mult;
        logic sweep;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sweep_last;
    } t_status;

    // off-diagonal part of q[(p,q)][(s,t)], rate term excluded
    function automatic logic signed [TERM_W-1:0] struct_term(
        input logic [CUR_W-1:0]    p,
        input logic [CUR_W-1:0]    q,
        input logic [CUR_W-1:0]    s,
        input logic [CUR_W-1:0]    t,
        input logic [WEIGHT_W-1:0] m1,
        input logic [WEIGHT_W-1:0] m2,
        input logic                alt
    );
        logic signed [TERM_W-1:0] v;
        logic signed [TERM_W-1:0] w1;
        logic signed [TERM_W-1:0] w12;
        v   = '0;
        w1  = signed'(TERM_W'(m1));
        w12 = signed'(TERM_W'(m1) + TERM_W'(m2));
        if (alt) begin
            if (s == q && t == p) v = v + ONE_Q;
            if (p == s) v = v + ONE_HALF_Q;
            if (t == p) v = v - ONE_Q;
            if (q == s) v = v - ONE_Q;
            if (q == t) v = v + ONE_HALF_Q;
        end else begin
            if (p == s) v = v + w12;
            if (t == p) v = v - w1;
            if (q == s) v = v - w1;
            if (q == t) v = v + w1;
        end
        return v;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(2147483647);
        lo = -hi - ACC_W'(1);
        if (v > hi) return OUT_W'(hi);
        if (v < lo) return OUT_W'(lo);
        return v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/qic_ctrl.sv -----
`default_nettype none

module qic_ctrl
    import qic_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire logic    i_command,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_command == CMD_READ) begin
                        o_cmd.accept_read = 1'b1;
                        n_state           = ST_DIV;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_SWEEP;
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/qic_datapath.sv -----
`default_nettype none

module qic_datapath
    import qic_pkg::*;
#(
    parameter int CURRENCIES = DEF_CURRENCIES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic [2:0]            i_currency_from,
    input  wire logic [2:0]            i_currency_to,
    input  wire logic signed [RATE_W-1:0] i_rate,
    input  wire logic [VAR_W-1:0]      i_var_row,
    input  wire logic [VAR_W-1:0]      i_var_col,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [WEIGHT_W-1:0]   i_cfg_data,
    output logic signed [OUT_W-1:0]    o_coupling,
    output logic signed [OUT_W-1:0]    o_field,
    output logic                       o_result_valid
);

    localparam int NV = CURRENCIES * CURRENCIES;
    localparam int AW = $clog2(NV);
    localparam logic [CMP_W-1:0] NV_C   = CMP_W'(NV);
    localparam logic [CMP_W-1:0] N_C    = CMP_W'(CURRENCIES);
    localparam logic [VAR_W-1:0] N_V    = VAR_W'(CURRENCIES);
    localparam logic [CUR_W-1:0] N_LAST = CUR_W'(CURRENCIES - 1);

    logic [WEIGHT_W-1:0] r_m1;
    logic [WEIGHT_W-1:0] r_m2;
    logic [WEIGHT_W-1:0] r_mc;
    logic                r_alt;

    logic [RATE_W-1:0] mem [NV];
    logic [NV-1:0]     r_tvalid;
    logic [RATE_W-1:0] r_rd;
    logic              r_rd_vld;

    logic [VAR_W-1:0] r_a;
    logic [VAR_W-1:0] r_b;
    logic [VAR_W-1:0] r_rem_a;
    logic [VAR_W-1:0] r_rem_b;
    logic [VAR_W-1:0] r_pa;
    logic [VAR_W-1:0] r_pb;

    logic [CUR_W-1:0] r_s;
    logic [CUR_W-1:0] r_t;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [OUT_W-1:0] r_coupling;
    logic signed [OUT_W-1:0] r_field;
    logic                    r_out_vld;

    logic [CMP_W-1:0]         wr_idx;
    logic                     load_ok;
    logic [AW-1:0]            rd_idx;
    logic signed [RATE_W-1:0] rate_val;
    logic                     a_ok;
    logic                     b_ok;
    logic [CUR_W-1:0]         ap;
    logic [CUR_W-1:0]         aq;
    logic [CUR_W-1:0]         bp;
    logic [CUR_W-1:0]         bq;
    logic signed [DIAG_W-1:0] diag;
    logic signed [TERM_W-1:0] term_ac;
    logic signed [TERM_W-1:0] term_ca;
    logic signed [TERM_W-1:0] term_ab;
    logic signed [ACC_W-1:0]  fld_sum;
    logic signed [ACC_W-1:0]  cpl_sum;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1  <= WEIGHT_RESET;
            r_m2  <= WEIGHT_RESET;
            r_mc  <= WEIGHT_RESET;
            r_alt <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINK:  r_m1  <= i_cfg_data;
                REG_DIAG:  r_m2  <= i_cfg_data;
                REG_SCALE: r_mc  <= i_cfg_data;
                REG_FORM:  r_alt <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    // rate table
    assign wr_idx  = CMP_W'(i_currency_from) * N_C + CMP_W'(i_currency_to);
    assign load_ok = (CMP_W'(i_currency_from) < N_C) && (CMP_W'(i_currency_to) < N_C);
    assign rd_idx  = AW'(CMP_W'(r_a));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            mem[wr_idx[AW-1:0]] <= i_rate;
        end
        r_rd <= mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.load && load_ok) r_tvalid[wr_idx[AW-1:0]] <= 1'b1;
            r_rd_vld <= r_tvalid[rd_idx];
        end
    end

    assign rate_val = r_rd_vld ? signed'(r_rd) : '0;

    // variable index split into currency pair by repeated subtraction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_read) begin
            r_a     <= i_var_row;
            r_b     <= i_var_col;
            r_rem_a <= i_var_row;
            r_rem_b <= i_var_col;
            r_pa    <= '0;
            r_pb    <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem_a >= N_V) begin
                r_rem_a <= r_rem_a - N_V;
                r_pa    <= r_pa + VAR_W'(1);
            end
            if (r_rem_b >= N_V) begin
                r_rem_b <= r_rem_b - N_V;
                r_pb    <= r_pb + VAR_W'(1);
            end
        end
    end

    assign o_status.div_done   = (r_rem_a < N_V) && (r_rem_b < N_V);
    assign o_status.sweep_last = (r_s == N_LAST) && (r_t == N_LAST);

    assign a_ok = CMP_W'(r_a) < NV_C;
    assign b_ok = CMP_W'(r_b) < NV_C;
    assign ap   = r_pa[CUR_W-1:0];
    assign aq   = r_rem_a[CUR_W-1:0];
    assign bp   = r_pb[CUR_W-1:0];
    assign bq   = r_rem_b[CUR_W-1:0];

    // scaled rate and diagonal term
    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= PROD_W'(rate_val) * signed'(PROD_W'(r_mc));
        end
    end

    always_comb begin
        if (r_alt) begin
            diag = -(DIAG_W'(signed'(r_prod[PROD_W-1:8])) + DIAG_W'(ONE_Q));
        end else begin
            diag = -(DIAG_W'(rate_val) + signed'(DIAG_W'(r_m2)));
        end
    end

    // row and column sweep
    assign term_ac = struct_term(ap, aq, r_s, r_t, r_m1, r_m2, r_alt);
    assign term_ca = struct_term(r_s, r_t, ap, aq, r_m1, r_m2, r_alt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_s   <= '0;
            r_t   <= '0;
            r_acc <= '0;
        end else if (i_cmd.sweep) begin
            r_acc <= r_acc + ACC_W'(term_ac) + ACC_W'(term_ca);
            if (r_t == N_LAST) begin
                r_t <= '0;
                r_s <= r_s + CUR_W'(1);
            end else begin
                r_t <= r_t + CUR_W'(1);
            end
        end
    end

    assign term_ab = struct_term(ap, aq, bp, bq, r_m1, r_m2, r_alt);
    assign fld_sum = r_acc + ACC_W'(diag) + ACC_W'(diag);

    always_comb begin
        cpl_sum = ACC_W'(term_ab);
        if (r_a == r_b) cpl_sum = cpl_sum + ACC_W'(diag);
        cpl_sum = -(cpl_sum + cpl_sum);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_field    <= a_ok ? signed'(sat_out(fld_sum)) : '0;
            r_coupling <= (a_ok && b_ok) ? signed'(sat_out(cpl_sum)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.finish;
        end
    end

    assign o_coupling     = r_coupling;
    assign o_field        = r_field;
    assign o_result_valid = r_out_vld;

endmodule

`default_nettype wire

// ----- design/qubo_to_ising_coefficients.sv -----
// read: accepted, then split by subtraction (ST_DIV), multiply (ST_MULT), a sweep
// over all n*n (s,t) pairs (one pair per cycle, both terms into one accumulator)
// and finish (ST_FINISH); the result strobe is registered from the finish state
// load: no result, busy stays low; a new start is taken in the strobe cycle
// the receiver cannot stall; the strobe is high for one cycle only; results hold after it
// synchronous active-low reset: weights 1.0, table entries read zero, sequencer idle
`default_nettype none

module qubo_to_ising_coefficients
    import qic_pkg::*;
#(
    parameter int CURRENCIES = DEF_CURRENCIES
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_command,
    input  wire logic [2:0]               i_currency_from,
    input  wire logic [2:0]               i_currency_to,
    input  wire logic signed [RATE_W-1:0] i_rate,
    input  wire logic [VAR_W-1:0]         i_var_row,
    input  wire logic [VAR_W-1:0]         i_var_col,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [WEIGHT_W-1:0]      i_cfg_data,
    output logic signed [OUT_W-1:0]       o_coupling,
    output logic signed [OUT_W-1:0]       o_field,
    output logic                          o_result_valid
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    qic_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_status  (status),
        .o_cmd     (cmd),
        .busy      (busy)
    );

    qic_datapath #(
        .CURRENCIES (CURRENCIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_currency_from (i_currency_from),
        .i_currency_to   (i_currency_to),
        .i_rate          (i_rate),
        .i_var_row       (i_var_row),
        .i_var_col       (i_var_col),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_coupling      (o_coupling),
        .o_field         (o_field),
        .o_result_valid  (o_result_valid)
    );

endmodule

`default_nettype wire

// ----- design/qic_checker.sv -----
`default_nettype none

module qic_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_command,
    input wire logic o_result_valid
);

    // strobe is a single cycle per read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command) |=> busy)
        else $error("read transfer not started");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_command) |=> !busy && !o_result_valid)
        else $error("load transfer gave busy or result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

endmodule

bind qubo_to_ising_coefficients qic_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_command      (i_command),
    .o_result_valid (o_result_valid)
);

`default_nettype wire
